FILE: hdl/cpl_pkg.sv
// ----------------------------------------------------------------------------
// Column peak contour levels: shared package
// Field widths, default sizes and the request and response types of the
// level divider.
// ----------------------------------------------------------------------------
package cpl_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int LEVEL_W      = 16;
  localparam int TOTAL_W      = 22;
  localparam int ROWS_CFG_W   = 7;
  localparam int ROW_OUT_W    = 6;
  localparam int MAX_ROWS_DEF = 64;
  localparam int LEVELS_DEF   = 256;

  // Request to the level divider: one start pulse with its operands.
  typedef struct packed {
    logic               start;
    logic [TOTAL_W-1:0] run_sum;
    logic [TOTAL_W-1:0] total;
  } div_req_t;

  // Response of the level divider: a one-cycle done pulse and the level.
  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } div_rsp_t;

endpackage

FILE: hdl/cpl_level_div.sv
// ----------------------------------------------------------------------------
// Level divider
// Computes floor((total - run_sum) * 2^16 / total), saturated, by restoring
// division with one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cpl_level_div (
  input  logic               clk,
  input  logic               rst,
  input  cpl_pkg::div_req_t  req,
  output cpl_pkg::div_rsp_t  rsp
);

  localparam int CNT_W = $clog2(cpl_pkg::LEVEL_W + 1);

  logic                         busy;
  logic                         done;
  logic [CNT_W-1:0]             cnt;
  logic [cpl_pkg::TOTAL_W-1:0]  rem;
  logic [cpl_pkg::TOTAL_W-1:0]  divisor;
  logic [cpl_pkg::LEVEL_W-1:0]  quo;

  logic [cpl_pkg::TOTAL_W:0]    rem2;
  logic                         q_bit;
  logic [cpl_pkg::TOTAL_W-1:0]  rem_next;

  // One restoring step: the partial remainder always stays below the divisor.
  always_comb begin
    rem2     = {rem, 1'b0};
    q_bit    = (rem2 >= {1'b0, divisor});
    rem_next = q_bit ? cpl_pkg::TOTAL_W'(rem2 - {1'b0, divisor})
                     : cpl_pkg::TOTAL_W'(rem2);
  end

  // Special cases finish at once; otherwise sixteen steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        divisor <= req.total;
        if (req.total == '0 || req.run_sum >= req.total) begin
          quo  <= '0;
          done <= 1'b1;
          busy <= 1'b0;
        end else if (req.run_sum == '0) begin
          quo  <= '1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          rem  <= req.total - req.run_sum;
          quo  <= '0;
          cnt  <= CNT_W'(cpl_pkg::LEVEL_W);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[cpl_pkg::LEVEL_W-2:0], q_bit};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.level = quo;

endmodule

FILE: hdl/column_peak_contour_levels.sv
// ----------------------------------------------------------------------------
// Column peak contour levels
// Loads one column, then shrinks the run around its peak for every threshold
// and emits one contour level per row.
// ----------------------------------------------------------------------------
// Loading takes one sample per cycle. After the last sample of an n-row column
// come the path-minimum walk down and then up from the peak, the
// THRESHOLD_LEVELS-1 threshold passes, each with one divider pass when the run
// changes, the final fill of the rows still in the run and the emission of one
// result per row; no new sample is taken until the last result is loaded.
// Reset (rst, synchronous) clears control and sets rows_in_use to MAX_ROWS;
// the memories are not cleared.
// ----------------------------------------------------------------------------
module column_peak_contour_levels #(
  parameter int MAX_ROWS         = cpl_pkg::MAX_ROWS_DEF,
  parameter int THRESHOLD_LEVELS = cpl_pkg::LEVELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cpl_pkg::ROWS_CFG_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cpl_pkg::SAMPLE_W-1:0]     sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cpl_pkg::ROW_OUT_W-1:0]    row_index,
  output logic [cpl_pkg::LEVEL_W-1:0]      level,
  output logic                             column_done
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int KW = $clog2(THRESHOLD_LEVELS);
  localparam int TW = $clog2(THRESHOLD_LEVELS + 1);
  localparam int PW = cpl_pkg::SAMPLE_W + TW;
  localparam int SW = cpl_pkg::SAMPLE_W;

  typedef enum logic [14:0] {
    S_LOAD    = 15'b000000000000001,
    S_PMDN_RD = 15'b000000000000010,
    S_PMDN_WR = 15'b000000000000100,
    S_PMUP_RD = 15'b000000000001000,
    S_PMUP_WR = 15'b000000000010000,
    S_LO_RD   = 15'b000000000100000,
    S_LO_CK   = 15'b000000001000000,
    S_HI_RD   = 15'b000000010000000,
    S_HI_CK   = 15'b000000100000000,
    S_DIV_GO  = 15'b000001000000000,
    S_DIV_WT  = 15'b000010000000000,
    S_NEXT_K  = 15'b000100000000000,
    S_FILL    = 15'b001000000000000,
    S_EM_RD   = 15'b010000000000000,
    S_EM_WR   = 15'b100000000000000
  } state_t;

  state_t                          state;
  logic [cpl_pkg::ROWS_CFG_W-1:0]  rows_in_use;
  logic [CW-1:0]                   loaded;
  logic [cpl_pkg::TOTAL_W-1:0]     total;
  logic [SW-1:0]                   peak;
  logic [RW-1:0]                   peak_row;
  logic [RW-1:0]                   ptr;
  logic [RW-1:0]                   lo;
  logic [RW-1:0]                   hi;
  logic [cpl_pkg::TOTAL_W-1:0]     run_sum;
  logic [cpl_pkg::LEVEL_W-1:0]     cur_level;
  logic [KW-1:0]                   k;
  logic [PW-1:0]                   bar;
  logic                            changed;
  logic [SW-1:0]                   pm_run;

  // Memories: samples, path minima from the peak, and levels.
  logic [SW-1:0]                   col_mem [MAX_ROWS];
  logic [SW-1:0]                   pm_mem  [MAX_ROWS];
  logic [cpl_pkg::LEVEL_W-1:0]     lvl_mem [MAX_ROWS];
  logic [SW-1:0]                   col_q;
  logic [SW-1:0]                   pm_q;
  logic [cpl_pkg::LEVEL_W-1:0]     lvl_q;

  logic [CW-1:0]                   eff_rows;
  logic [CW-1:0]                   loaded_inc;
  logic [RW-1:0]                   n_last;
  logic                            in_acc;
  logic                            pk_upd;
  logic [RW-1:0]                   pk_row_new;
  logic [SW-1:0]                   pk_new;
  logic [SW-1:0]                   pm_new;
  logic                            fails;
  logic                            lo_drop;
  logic                            hi_drop;
  logic [RW-1:0]                   rd_addr;
  logic                            lvl_we;
  logic [RW-1:0]                   lvl_wa;
  logic                            out_load;
  cpl_pkg::div_req_t               div_req;
  cpl_pkg::div_rsp_t               div_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_LOAD);
  assign in_acc    = in_valid && !in_stall;

  // Row count in force, with out-of-range settings clamped.
  always_comb begin
    if (rows_in_use == '0) begin
      eff_rows = CW'(1);
    end else if (rows_in_use > cpl_pkg::ROWS_CFG_W'(MAX_ROWS)) begin
      eff_rows = CW'(MAX_ROWS);
    end else begin
      eff_rows = CW'(rows_in_use);
    end
  end

  // Loading and threshold helpers.
  always_comb begin
    loaded_inc = loaded + CW'(1);
    n_last     = RW'(loaded - CW'(1));
    pk_upd     = (loaded == '0) || (sample > peak);
    pk_row_new = pk_upd ? RW'(loaded) : peak_row;
    pk_new     = pk_upd ? sample : peak;
    pm_new     = (col_q < pm_run) ? col_q : pm_run;
    fails      = (PW'(pm_q) * PW'(THRESHOLD_LEVELS)) < bar;
    lo_drop    = fails && (lo != peak_row);
    hi_drop    = fails && (hi != peak_row);
    out_load   = (state == S_EM_WR) && (!out_valid || !out_stall);
  end

  // Read address follows the state; level writes come from the run ends or the fill.
  always_comb begin
    priority if (state == S_LO_RD) begin
      rd_addr = lo;
    end else if (state == S_HI_RD) begin
      rd_addr = hi;
    end else begin
      rd_addr = ptr;
    end
    lvl_we = ((state == S_LO_CK) && lo_drop) || ((state == S_HI_CK) && hi_drop) ||
             (state == S_FILL);
    priority if (state == S_LO_CK) begin
      lvl_wa = lo;
    end else if (state == S_HI_CK) begin
      lvl_wa = hi;
    end else begin
      lvl_wa = ptr;
    end
  end

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_mem[RW'(loaded)] <= sample;
    end
    if (state == S_PMDN_WR || state == S_PMUP_WR) begin
      pm_mem[ptr] <= pm_new;
    end
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= cur_level;
    end
    col_q <= col_mem[rd_addr];
    pm_q  <= pm_mem[rd_addr];
    lvl_q <= lvl_mem[rd_addr];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= cpl_pkg::ROWS_CFG_W'(MAX_ROWS);
    end else if (cfg_valid && cfg_ready) begin
      rows_in_use <= cfg_data;
    end
  end

  // Divider request.
  always_comb begin
    div_req.start   = (state == S_DIV_GO);
    div_req.run_sum = run_sum;
    div_req.total   = total;
  end

  cpl_level_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer: load, path-minimum walk, threshold sweep, fill, emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      loaded   <= '0;
      total    <= '0;
      peak     <= '0;
      peak_row <= '0;
      changed  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            total    <= total + cpl_pkg::TOTAL_W'(sample);
            loaded   <= loaded_inc;
            peak     <= pk_new;
            peak_row <= pk_row_new;
            if (loaded_inc >= eff_rows) begin
              ptr    <= pk_row_new;
              pm_run <= pk_new;
              state  <= S_PMDN_RD;
            end
          end
        end
        S_PMDN_RD: state <= S_PMDN_WR;
        S_PMDN_WR: begin
          if (ptr == '0) begin
            ptr    <= peak_row;
            pm_run <= peak;
            state  <= S_PMUP_RD;
          end else begin
            pm_run <= pm_new;
            ptr    <= ptr - RW'(1);
            state  <= S_PMDN_RD;
          end
        end
        S_PMUP_RD: state <= S_PMUP_WR;
        S_PMUP_WR: begin
          pm_run <= pm_new;
          if (ptr == n_last) begin
            lo        <= '0;
            hi        <= n_last;
            run_sum   <= total;
            cur_level <= '0;
            k         <= KW'(1);
            bar       <= PW'(peak);
            changed   <= 1'b0;
            state     <= S_LO_RD;
          end else begin
            ptr   <= ptr + RW'(1);
            state <= S_PMUP_RD;
          end
        end
        S_LO_RD: state <= S_LO_CK;
        S_LO_CK: begin
          if (lo_drop) begin
            run_sum <= run_sum - cpl_pkg::TOTAL_W'(col_q);
            lo      <= lo + RW'(1);
            changed <= 1'b1;
            state   <= S_LO_RD;
          end else begin
            state <= S_HI_RD;
          end
        end
        S_HI_RD: state <= S_HI_CK;
        S_HI_CK: begin
          if (hi_drop) begin
            run_sum <= run_sum - cpl_pkg::TOTAL_W'(col_q);
            hi      <= hi - RW'(1);
            changed <= 1'b1;
            state   <= S_HI_RD;
          end else begin
            state <= changed ? S_DIV_GO : S_NEXT_K;
          end
        end
        S_DIV_GO: state <= S_DIV_WT;
        S_DIV_WT: begin
          if (div_rsp.done) begin
            cur_level <= div_rsp.level;
            state     <= S_NEXT_K;
          end
        end
        S_NEXT_K: begin
          changed <= 1'b0;
          if (k == KW'(THRESHOLD_LEVELS - 1)) begin
            ptr   <= lo;
            state <= S_FILL;
          end else begin
            k     <= k + KW'(1);
            bar   <= bar + PW'(peak);
            state <= S_LO_RD;
          end
        end
        S_FILL: begin
          if (ptr == hi) begin
            ptr   <= '0;
            state <= S_EM_RD;
          end else begin
            ptr <= ptr + RW'(1);
          end
        end
        S_EM_RD: state <= S_EM_WR;
        S_EM_WR: begin
          if (out_load) begin
            if (ptr == n_last) begin
              loaded   <= '0;
              total    <= '0;
              peak     <= '0;
              peak_row <= '0;
              state    <= S_LOAD;
            end else begin
              ptr   <= ptr + RW'(1);
              state <= S_EM_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Output register: holds an item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      row_index   <= cpl_pkg::ROW_OUT_W'(ptr);
      level       <= lvl_q;
      column_done <= (ptr == n_last);
    end
  end

endmodule

FILE: hdl/cpl_checker.sv
// ----------------------------------------------------------------------------
// Column peak contour levels: port checker
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
module cpl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [cpl_pkg::ROWS_CFG_W-1:0]  cfg_data,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [cpl_pkg::SAMPLE_W-1:0]    sample,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [cpl_pkg::ROW_OUT_W-1:0]   row_index,
  input logic [cpl_pkg::LEVEL_W-1:0]     level,
  input logic                            column_done
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_index) && $stable(level) &&
                               $stable(column_done))
    else $error("result item changed while stalled");

  // While a column is being emitted no new sample is taken.
  a_emit_blocks_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && !column_done |-> in_stall)
    else $error("sample accepted while a column was still being emitted");

  // After a sample is taken, only the last item of a column may be pending.
  a_load_no_rows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid || column_done)
    else $error("mid-column result item pending while loading");

  // Reset leaves no result item pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result item pending after reset");

endmodule

bind column_peak_contour_levels cpl_checker u_cpl_checker (.*);
